FILE: design/lfpd_pkg.sv
// Shared types, register indexes and constants of the line follower PD controller.
`default_nettype none
package lfpd_pkg;

    localparam int NUM_SENSORS = 8;

    // Configuration register indexes
    localparam logic [2:0] REG_THR_LO      = 3'd0;
    localparam logic [2:0] REG_THR_HI      = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN   = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd3;
    localparam logic [2:0] REG_SPEED_LIMIT = 3'd4;
    localparam logic [2:0] REG_LEFT_BASE   = 3'd5;
    localparam logic [2:0] REG_RIGHT_BASE  = 3'd6;
    localparam logic [2:0] REG_SPIN_SPEED  = 3'd7;

    localparam logic signed [8:0] DRIVE_MAX = 9'sd255;
    localparam logic [3:0]        COUNT_ALL = 4'd8;

    typedef enum logic [1:0] {
        MODE_FOLLOW  = 2'd0,
        MODE_SPIN    = 2'd1,
        MODE_CONFIRM = 2'd2,
        MODE_STOP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_LEFT  = 2'd1,
        TURN_RIGHT = 2'd2
    } t_turn;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MERGE,
        SEQ_RECIP,
        SEQ_POS,
        SEQ_ERROR,
        SEQ_PRODUCT,
        SEQ_COMMIT,
        SEQ_OUTPUT
    } t_seq_state;

    typedef struct packed {
        logic merge_en;
        logic recip_en;
        logic pos_en;
        logic error_en;
        logic product_en;
        logic commit_en;
    } t_step;

    typedef struct packed {
        logic [7:0] prop_gain;
        logic [7:0] deriv_gain;
        logic [7:0] speed_limit;
        logic [7:0] left_base;
        logic [7:0] right_base;
        logic [7:0] spin_speed;
    } t_gains;

    typedef struct packed {
        t_turn      turn;
        t_mode      mode;
        logic [7:0] right_pwm;
        logic       right_fwd;
        logic [7:0] left_pwm;
        logic       left_fwd;
    } t_motor_status;

endpackage
`default_nettype wire

FILE: design/lfpd_lane.sv
// One sensor lane: compare a sample with its threshold and register the hit.
`default_nettype none
module lfpd_lane
    import lfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [SAMPLE_BITS-1:0] i_thresh,
    output logic                        o_hit
);

    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= (i_sample > i_thresh);
        end
    end

    assign o_hit = r_hit;

endmodule
`default_nettype wire

FILE: design/lfpd_merge.sv
// Merge the lane hits into a hit pattern, a hit count and a weighted sum.
`default_nettype none
module lfpd_merge
    import lfpd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [NUM_SENSORS-1:0] i_hits,
    output logic [NUM_SENSORS-1:0]      o_bits,
    output logic [3:0]                  o_count,
    output logic [5:0]                  o_wsum
);

    logic [NUM_SENSORS-1:0] r_bits;
    logic [3:0]             r_count;
    logic [5:0]             r_wsum;
    logic [3:0]             n_count;
    logic [5:0]             n_wsum;

    // weights run 1..8 from the leftmost sensor
    always_comb begin
        n_count = '0;
        n_wsum  = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (i_hits[i]) begin
                n_count = n_count + 4'd1;
                n_wsum  = n_wsum + 6'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bits  <= i_hits;
            r_count <= n_count;
            r_wsum  <= n_wsum;
        end
    end

    assign o_bits  = r_bits;
    assign o_count = r_count;
    assign o_wsum  = r_wsum;

endmodule
`default_nettype wire

FILE: design/lfpd_div.sv
// Position divider: weighted sum over hit count by reciprocal multiply and one correction.
`default_nettype none
module lfpd_div
    import lfpd_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [5:0]             i_wsum,
    input  wire logic [3:0]             i_count,
    output logic [FRAC_BITS+3:0]        o_quot
);

    localparam int NUM_W  = FRAC_BITS + 6;
    localparam int SHIFT  = NUM_W;
    localparam int RCP_W  = SHIFT + 1;
    localparam int PROD_W = NUM_W + RCP_W;
    localparam int POS_W  = FRAC_BITS + 4;
    localparam int CHK_W  = NUM_W + 4;

    localparam logic [RCP_W-1:0] RCP_1 = RCP_W'((64'd1 << SHIFT) / 64'd1);
    localparam logic [RCP_W-1:0] RCP_2 = RCP_W'((64'd1 << SHIFT) / 64'd2);
    localparam logic [RCP_W-1:0] RCP_3 = RCP_W'((64'd1 << SHIFT) / 64'd3);
    localparam logic [RCP_W-1:0] RCP_4 = RCP_W'((64'd1 << SHIFT) / 64'd4);
    localparam logic [RCP_W-1:0] RCP_5 = RCP_W'((64'd1 << SHIFT) / 64'd5);
    localparam logic [RCP_W-1:0] RCP_6 = RCP_W'((64'd1 << SHIFT) / 64'd6);
    localparam logic [RCP_W-1:0] RCP_7 = RCP_W'((64'd1 << SHIFT) / 64'd7);
    localparam logic [RCP_W-1:0] RCP_8 = RCP_W'((64'd1 << SHIFT) / 64'd8);

    logic [RCP_W-1:0]  rcp;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  r_num;
    logic [3:0]        r_cnt;
    logic [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]  q_est;
    logic [CHK_W-1:0]  q_back;
    logic [CHK_W-1:0]  rem;
    logic [NUM_W-1:0]  q_fix;

    always_comb begin
        case (i_count)
            4'd1:    rcp = RCP_1;
            4'd2:    rcp = RCP_2;
            4'd3:    rcp = RCP_3;
            4'd4:    rcp = RCP_4;
            4'd5:    rcp = RCP_5;
            4'd6:    rcp = RCP_6;
            4'd7:    rcp = RCP_7;
            4'd8:    rcp = RCP_8;
            default: rcp = '0;
        endcase
    end

    assign num = {i_wsum, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= num;
            r_cnt  <= i_count;
            r_prod <= PROD_W'(num) * PROD_W'(rcp);
        end
    end

    // the estimate is never high and at most one low: add one when a whole divisor remains
    always_comb begin
        q_est  = r_prod[SHIFT +: NUM_W];
        q_back = CHK_W'(q_est) * CHK_W'(r_cnt);
        rem    = CHK_W'(r_num) - q_back;
        q_fix  = (rem >= CHK_W'(r_cnt)) ? q_est + NUM_W'(1) : q_est;
    end

    assign o_quot = q_fix[POS_W-1:0];

endmodule
`default_nettype wire

FILE: design/lfpd_ctrl.sv
// PD steering and mode machine: position hold, error, gain products, drives and turn memory.
`default_nettype none
module lfpd_ctrl
    import lfpd_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_step                  i_step,
    input  wire t_gains                 i_gains,
    input  wire logic [NUM_SENSORS-1:0] i_bits,
    input  wire logic [3:0]             i_count,
    input  wire logic [FRAC_BITS+3:0]   i_quot,
    output t_motor_status               o_status,
    output logic [FRAC_BITS+3:0]        o_position
);

    localparam int POS_W  = FRAC_BITS + 4;
    localparam int ERR_W  = FRAC_BITS + 4;
    localparam int DIFF_W = FRAC_BITS + 5;
    localparam int P_W    = FRAC_BITS + 13;
    localparam int D_W    = FRAC_BITS + 14;
    localparam int SUM_W  = FRAC_BITS + 16;

    localparam logic [POS_W-1:0]        CENTER = POS_W'(9 << (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] ROUND  = SUM_W'((1 << FRAC_BITS) - 1);

    // control state
    t_mode                    r_mode, n_mode;
    t_turn                    r_turn, n_turn;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic signed [ERR_W-1:0]  r_last_err, n_last_err;
    logic signed [8:0]        r_left, n_left;
    logic signed [8:0]        r_right, n_right;

    // datapath
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [P_W-1:0]    r_p;
    logic signed [D_W-1:0]    r_d;
    logic signed [POS_W:0]    err_wide;
    logic signed [ERR_W-1:0]  err_now;
    logic signed [DIFF_W-1:0] diff_now;
    logic signed [SUM_W-1:0]  pd;
    logic signed [SUM_W-1:0]  left_sum;
    logic signed [SUM_W-1:0]  right_sum;
    logic signed [8:0]        left_pd;
    logic signed [8:0]        right_pd;
    logic signed [8:0]        spin_drive;
    t_turn                    turn_follow;

    // truncate toward zero after dropping the fraction, then saturate
    function automatic logic signed [8:0] drive_of(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        begin
            t = (v < 0) ? ((v + ROUND) >>> FRAC_BITS) : (v >>> FRAC_BITS);
            if (t > SUM_W'(DRIVE_MAX)) begin
                drive_of = DRIVE_MAX;
            end else if (t < -SUM_W'(DRIVE_MAX)) begin
                drive_of = -DRIVE_MAX;
            end else begin
                drive_of = t[8:0];
            end
        end
    endfunction

    function automatic logic [8:0] motor_of(input logic signed [8:0] drive,
                                            input logic [7:0] limit);
        logic signed [8:0] mag;
        logic [7:0]        mag8;
        begin
            mag  = drive[8] ? -drive : drive;
            mag8 = mag[7:0];
            motor_of = {(mag8 > limit) ? limit : mag8, (!drive[8] && (drive != '0))};
        end
    endfunction

    assign err_wide   = $signed({1'b0, CENTER}) - $signed({1'b0, r_pos});
    assign err_now    = err_wide[ERR_W-1:0];
    assign diff_now   = {err_now[ERR_W-1], err_now} - {r_last_err[ERR_W-1], r_last_err};
    assign pd         = r_p + r_d;
    assign left_sum   = $signed({{(SUM_W-FRAC_BITS-8){1'b0}}, i_gains.left_base,
                                 {FRAC_BITS{1'b0}}}) + pd;
    assign right_sum  = $signed({{(SUM_W-FRAC_BITS-8){1'b0}}, i_gains.right_base,
                                 {FRAC_BITS{1'b0}}}) - pd;
    assign left_pd    = drive_of(left_sum);
    assign right_pd   = drive_of(right_sum);
    assign spin_drive = $signed({1'b0, i_gains.spin_speed});

    // edge-only patterns remember a turn
    always_comb begin
        turn_follow = r_turn;
        if ((i_bits[1:0] != '0) && (i_bits[7:2] == '0)) begin
            turn_follow = TURN_LEFT;
        end else if ((i_bits[7:6] != '0) && (i_bits[5:0] == '0)) begin
            turn_follow = TURN_RIGHT;
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_turn     = r_turn;
        n_pos      = r_pos;
        n_last_err = r_last_err;
        n_left     = r_left;
        n_right    = r_right;
        if (i_step.pos_en && (i_count != '0)) begin
            n_pos = i_quot;
        end
        if (i_step.commit_en) begin
            unique case (r_mode)
                MODE_FOLLOW: begin
                    n_last_err = r_err;
                    n_left     = left_pd;
                    n_right    = right_pd;
                    n_turn     = turn_follow;
                    if (i_count == '0) begin
                        if (turn_follow == TURN_LEFT) begin
                            n_left  = -spin_drive;
                            n_right = spin_drive;
                        end else begin
                            n_left  = spin_drive;
                            n_right = -spin_drive;
                        end
                        n_mode = MODE_SPIN;
                    end else if (i_count == COUNT_ALL) begin
                        n_mode = MODE_CONFIRM;
                    end
                end
                MODE_SPIN: begin
                    if (i_bits[4:3] != '0) begin
                        n_turn = TURN_NONE;
                        n_mode = MODE_FOLLOW;
                    end
                end
                MODE_CONFIRM: begin
                    if (i_count == COUNT_ALL) begin
                        n_left  = '0;
                        n_right = '0;
                        n_mode  = MODE_STOP;
                    end else begin
                        // nothing seen after all-black: a T-section, go right later
                        if (i_count == '0) begin
                            n_turn = TURN_RIGHT;
                        end
                        n_mode = MODE_FOLLOW;
                    end
                end
                MODE_STOP: begin
                    if (i_count != COUNT_ALL) begin
                        n_mode = MODE_FOLLOW;
                    end
                end
                default: begin
                    n_mode = MODE_FOLLOW;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_FOLLOW;
            r_turn     <= TURN_NONE;
            r_pos      <= '0;
            r_last_err <= '0;
            r_left     <= '0;
            r_right    <= '0;
        end else begin
            r_mode     <= n_mode;
            r_turn     <= n_turn;
            r_pos      <= n_pos;
            r_last_err <= n_last_err;
            r_left     <= n_left;
            r_right    <= n_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.error_en) begin
            r_err  <= err_now;
            r_diff <= diff_now;
        end
        if (i_step.product_en) begin
            r_p <= r_err * $signed({1'b0, i_gains.prop_gain});
            r_d <= r_diff * $signed({1'b0, i_gains.deriv_gain});
        end
    end

    always_comb begin
        o_status.turn = r_turn;
        o_status.mode = r_mode;
        {o_status.left_pwm, o_status.left_fwd}   = motor_of(r_left, i_gains.speed_limit);
        {o_status.right_pwm, o_status.right_fwd} = motor_of(r_right, i_gains.speed_limit);
    end

    assign o_position = r_pos;

endmodule
`default_nettype wire

FILE: design/line_follower_pd_controller.sv
// Line follower PD controller: eight sensor lanes, merge, divider, PD and mode control.
// A new input transaction is taken only in idle, after the previous item has been loaded
// into the output register; the sequencer walks sense, merge, reciprocal multiply,
// position, error, gain multiply, commit and output load; a stalled sink holds output load.
// Reset (i_rst_n low, synchronous): follow mode, no turn, position, error and drives zero,
// configuration registers to their defaults, output register empty.
`default_nettype none
module line_follower_pd_controller
    import lfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input stream: reading_0 .. reading_7, SAMPLE_BITS each, reading_0 lowest
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [NUM_SENSORS*SAMPLE_BITS-1:0] s_axis_tdata,
    // result stream, from bit 0 up: left_forward, left_pwm[8], right_forward,
    // right_pwm[8], mode_now[2], pending_turn[2], position_q8[FRAC_BITS+4], zero pad
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [((FRAC_BITS+26+7)/8)*8-1:0]  m_axis_tdata,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [4*SAMPLE_BITS-1:0]      i_cfg_data
);

    localparam int POS_W = FRAC_BITS + 4;
    localparam int GRP_W = 4 * SAMPLE_BITS;
    localparam int OUT_W = ((FRAC_BITS + 26 + 7) / 8) * 8;

    // configuration registers
    logic [GRP_W-1:0] r_thr_lo;
    logic [GRP_W-1:0] r_thr_hi;
    t_gains           r_gains;

    // sequencer
    t_seq_state       r_state, n_state;
    t_step            step;
    logic             accept;
    logic             out_free;

    // output register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    // datapath links
    logic [NUM_SENSORS-1:0] hits;
    logic [NUM_SENSORS-1:0] bits;
    logic [3:0]             count;
    logic [5:0]             wsum;
    logic [POS_W-1:0]       quot;
    logic [POS_W-1:0]       position;
    t_motor_status          status;

    // the user must issue configuration writes only while idle; the block does not enforce it and holds ready high
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_lo            <= '0;
            r_thr_hi            <= '0;
            r_gains.prop_gain   <= 8'd15;
            r_gains.deriv_gain  <= 8'd80;
            r_gains.speed_limit <= 8'd250;
            r_gains.left_base   <= 8'd50;
            r_gains.right_base  <= 8'd50;
            r_gains.spin_speed  <= 8'd80;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_THR_LO:      r_thr_lo            <= i_cfg_data;
                REG_THR_HI:      r_thr_hi            <= i_cfg_data;
                REG_PROP_GAIN:   r_gains.prop_gain   <= i_cfg_data[7:0];
                REG_DERIV_GAIN:  r_gains.deriv_gain  <= i_cfg_data[7:0];
                REG_SPEED_LIMIT: r_gains.speed_limit <= i_cfg_data[7:0];
                REG_LEFT_BASE:   r_gains.left_base   <= i_cfg_data[7:0];
                REG_RIGHT_BASE:  r_gains.right_base  <= i_cfg_data[7:0];
                REG_SPIN_SPEED:  r_gains.spin_speed  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: take one item in idle, step it through the datapath, then wait for
    // room in the output register before going back to idle.
    assign s_axis_tready = (r_state == SEQ_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        step    = '0;
        unique case (r_state)
            SEQ_IDLE: begin
                if (accept) begin
                    n_state = SEQ_MERGE;
                end
            end
            SEQ_MERGE: begin
                step.merge_en = 1'b1;
                n_state       = SEQ_RECIP;
            end
            SEQ_RECIP: begin
                step.recip_en = 1'b1;
                n_state       = SEQ_POS;
            end
            SEQ_POS: begin
                step.pos_en = 1'b1;
                n_state     = SEQ_ERROR;
            end
            SEQ_ERROR: begin
                step.error_en = 1'b1;
                n_state       = SEQ_PRODUCT;
            end
            SEQ_PRODUCT: begin
                step.product_en = 1'b1;
                n_state         = SEQ_COMMIT;
            end
            SEQ_COMMIT: begin
                step.commit_en = 1'b1;
                n_state        = SEQ_OUTPUT;
            end
            SEQ_OUTPUT: begin
                if (out_free) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sensor lanes: each compares its own sample with its own threshold.
    genvar g;
    generate
        for (g = 0; g < NUM_SENSORS; g++) begin : g_lane
            logic [SAMPLE_BITS-1:0] thresh;
            if (g < 4) begin : g_lo
                assign thresh = r_thr_lo[g*SAMPLE_BITS +: SAMPLE_BITS];
            end else begin : g_hi
                assign thresh = r_thr_hi[(g-4)*SAMPLE_BITS +: SAMPLE_BITS];
            end
            lfpd_lane #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_lane (
                .i_clk    (i_clk),
                .i_en     (accept),
                .i_sample (s_axis_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
                .i_thresh (thresh),
                .o_hit    (hits[g])
            );
        end
    endgenerate

    lfpd_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (step.merge_en),
        .i_hits  (hits),
        .o_bits  (bits),
        .o_count (count),
        .o_wsum  (wsum)
    );

    lfpd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_en    (step.recip_en),
        .i_wsum  (wsum),
        .i_count (count),
        .o_quot  (quot)
    );

    lfpd_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_gains    (r_gains),
        .i_bits     (bits),
        .i_count    (count),
        .i_quot     (quot),
        .o_status   (status),
        .o_position (position)
    );

    // Output register: load once the commit has settled and the slot is free;
    // hold the transaction until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == SEQ_OUTPUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == SEQ_OUTPUT) && out_free) begin
            r_out_data <= OUT_W'({position, status.turn, status.mode, status.right_pwm,
                                  status.right_fwd, status.left_pwm, status.left_fwd});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

FILE: verif/lfpd_steer_checker.sv
// Checker for the line follower PD controller: predicts each steering result and compares it.
`timescale 1ns / 1ps
module lfpd_steer_checker
    import lfpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_frame_valid,
    input  wire logic        i_frame_ready,
    input  wire logic [95:0] i_frame_data,
    input  wire logic        i_drive_valid,
    input  wire logic        i_drive_ready,
    input  wire logic [39:0] i_drive_data,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    output int               o_pending,
    output int               o_errors
);

    localparam int     FRAC_BITS = 8;
    localparam longint CENTER_Q  = 9 * (1 << (FRAC_BITS - 1));
    localparam longint ONE_Q     = 1 << FRAC_BITS;
    localparam longint DRIVE_LIM = 255;

    typedef struct {
        t_motor_status motor;
        logic [11:0]   pos;
    } t_steer;

    // shadow configuration
    logic [47:0] thr_lo;
    logic [47:0] thr_hi;
    t_gains      gains;

    // predicted controller state
    t_mode       mode_q;
    t_turn       turn_q;
    logic [11:0] pos_q;
    longint      err_q;
    longint      ldrv_q;
    longint      rdrv_q;

    t_steer      expected_steer[$];
    int          fault_count;

    function automatic longint clamp_drive(longint v);
        if (v > DRIVE_LIM) return DRIVE_LIM;
        if (v < -DRIVE_LIM) return -DRIVE_LIM;
        return v;
    endfunction

    task automatic motor_word(input longint drv, output logic fwd, output logic [7:0] pwm);
        longint mag;
        longint lim;
        mag = (drv < 0) ? -drv : drv;
        lim = gains.speed_limit;
        fwd = (drv > 0);
        pwm = 8'((mag > lim) ? lim : mag);
    endtask

    task automatic predict_steer(input logic [95:0] frame);
        logic [7:0]  seen;
        logic [11:0] thr;
        int          hits;
        int          wsum;
        longint      err;
        longint      pd;
        longint      kp;
        longint      kd;
        longint      base_l;
        longint      base_r;
        longint      spin;
        longint      held;
        t_steer      want;
        seen = '0;
        hits = 0;
        wsum = 0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            thr = (i < 4) ? thr_lo[i*12 +: 12] : thr_hi[(i-4)*12 +: 12];
            if (frame[i*12 +: 12] > thr) begin
                seen[i] = 1'b1;
                hits++;
                wsum += i + 1;
            end
        end
        // hold the position when nothing sees the line
        if (hits != 0)
            pos_q = 12'((wsum << FRAC_BITS) / hits);

        case (mode_q)
            MODE_FOLLOW: begin
                kp     = gains.prop_gain;
                kd     = gains.deriv_gain;
                base_l = gains.left_base;
                base_r = gains.right_base;
                held   = pos_q;
                err    = CENTER_Q - held;
                pd     = err * kp + kd * (err - err_q);
                err_q  = err;
                ldrv_q = clamp_drive((base_l * ONE_Q + pd) / ONE_Q);
                rdrv_q = clamp_drive((base_r * ONE_Q - pd) / ONE_Q);
                if (seen[1:0] != 0 && seen[7:2] == 0)
                    turn_q = TURN_LEFT;
                else if (seen[7:6] != 0 && seen[5:0] == 0)
                    turn_q = TURN_RIGHT;
                if (hits == 0) begin
                    spin = gains.spin_speed;
                    if (turn_q == TURN_LEFT) begin
                        ldrv_q = -spin;
                        rdrv_q = spin;
                    end else begin
                        ldrv_q = spin;
                        rdrv_q = -spin;
                    end
                    mode_q = MODE_SPIN;
                end else if (hits == NUM_SENSORS) begin
                    mode_q = MODE_CONFIRM;
                end
            end
            MODE_SPIN: begin
                if (seen[3] || seen[4]) begin
                    turn_q = TURN_NONE;
                    mode_q = MODE_FOLLOW;
                end
            end
            MODE_CONFIRM: begin
                if (hits == NUM_SENSORS) begin
                    ldrv_q = 0;
                    rdrv_q = 0;
                    mode_q = MODE_STOP;
                end else begin
                    // a blank after all-black is a T-section: go right later
                    if (hits == 0)
                        turn_q = TURN_RIGHT;
                    mode_q = MODE_FOLLOW;
                end
            end
            default: begin
                if (hits != NUM_SENSORS)
                    mode_q = MODE_FOLLOW;
            end
        endcase

        motor_word(ldrv_q, want.motor.left_fwd, want.motor.left_pwm);
        motor_word(rdrv_q, want.motor.right_fwd, want.motor.right_pwm);
        want.motor.mode = mode_q;
        want.motor.turn = turn_q;
        want.pos        = pos_q;
        expected_steer.push_back(want);
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : watch
        t_motor_status got_motor;
        logic [11:0]   got_pos;
        logic [5:0]    got_pad;
        t_steer        want;
        if (!i_rst_n) begin
            thr_lo            = '0;
            thr_hi            = '0;
            gains.prop_gain   = 8'd15;
            gains.deriv_gain  = 8'd80;
            gains.speed_limit = 8'd250;
            gains.left_base   = 8'd50;
            gains.right_base  = 8'd50;
            gains.spin_speed  = 8'd80;
            mode_q            = MODE_FOLLOW;
            turn_q            = TURN_NONE;
            pos_q             = '0;
            err_q             = 0;
            ldrv_q            = 0;
            rdrv_q            = 0;
            fault_count       = 0;
            expected_steer.delete();
        end else begin
            if (i_drive_valid && i_drive_ready) begin
                got_motor = t_motor_status'(i_drive_data[21:0]);
                got_pos   = i_drive_data[33:22];
                got_pad   = i_drive_data[39:34];
                if (expected_steer.size() == 0) begin
                    note_fault($sformatf("result with nothing expected: data %h", i_drive_data));
                end else begin
                    want = expected_steer.pop_front();
                    if (got_motor !== want.motor || got_pos !== want.pos || got_pad !== '0)
                        note_fault($sformatf({"mismatch: expected lf=%0d lp=%0d rf=%0d rp=%0d ",
                            "mode=%0d turn=%0d pos=%0d pad=0, got lf=%0d lp=%0d rf=%0d rp=%0d ",
                            "mode=%0d turn=%0d pos=%0d pad=%0d"},
                            want.motor.left_fwd, want.motor.left_pwm, want.motor.right_fwd,
                            want.motor.right_pwm, want.motor.mode, want.motor.turn, want.pos,
                            got_motor.left_fwd, got_motor.left_pwm, got_motor.right_fwd,
                            got_motor.right_pwm, got_motor.mode, got_motor.turn, got_pos,
                            got_pad));
                end
            end
            if (i_frame_valid && i_frame_ready)
                predict_steer(i_frame_data);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_THR_LO:      thr_lo            = i_cfg_data;
                    REG_THR_HI:      thr_hi            = i_cfg_data;
                    REG_PROP_GAIN:   gains.prop_gain   = i_cfg_data[7:0];
                    REG_DERIV_GAIN:  gains.deriv_gain  = i_cfg_data[7:0];
                    REG_SPEED_LIMIT: gains.speed_limit = i_cfg_data[7:0];
                    REG_LEFT_BASE:   gains.left_base   = i_cfg_data[7:0];
                    REG_RIGHT_BASE:  gains.right_base  = i_cfg_data[7:0];
                    default:         gains.spin_speed  = i_cfg_data[7:0];
                endcase
            end
        end
        o_pending <= expected_steer.size();
        o_errors  <= fault_count;
    end

endmodule

FILE: verif/tb_line_follower_pd_controller.sv
// Testbench top for the line follower PD controller: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_line_follower_pd_controller;
    import lfpd_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 8;
    localparam int IN_W        = NUM_SENSORS * SAMPLE_BITS;
    localparam int OUT_W       = ((FRAC_BITS + 26 + 7) / 8) * 8;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index   = REG_THR_LO;
    logic [47:0]        i_cfg_data    = '0;

    int                 pending_steer;
    int                 fault_total;

    // flow control knobs, percentages of idle cycles
    int unsigned        sender_pct = 20;
    int unsigned        recv_pct   = 55;
    logic               hold_armed = 1'b0;
    bit                 hold_done  = 1'b0;
    int                 hold_left  = 0;

    // thresholds as last written, used to shape readings around them
    logic [11:0]        thr_set [NUM_SENSORS];
    int unsigned        sent_items = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    line_follower_pd_controller #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    lfpd_steer_checker steer_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (s_axis_tvalid),
        .i_frame_ready (s_axis_tready),
        .i_frame_data  (s_axis_tdata),
        .i_drive_valid (m_axis_tvalid),
        .i_drive_ready (m_axis_tready),
        .i_drive_data  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending_steer),
        .o_errors      (fault_total)
    );

    // Result side: random stalls, plus one long hold-off once armed so that the
    // block backs up and has to refuse input transactions.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     = hold_left - 1;
        end else if (hold_armed && !hold_done) begin
            hold_done     = 1'b1;
            hold_left     = 200;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // Build a frame whose sensors see the line exactly where the pattern says,
    // with readings drawn from the whole range on each side of the threshold.
    // A sensor whose threshold is full scale can never see the line.
    function automatic logic [IN_W-1:0] frame_for(logic [7:0] pat);
        logic [IN_W-1:0] f;
        f = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (pat[i] && thr_set[i] != 12'hFFF)
                f[i*SAMPLE_BITS +: SAMPLE_BITS] = 12'($urandom_range(4095, thr_set[i] + 32'd1));
            else
                f[i*SAMPLE_BITS +: SAMPLE_BITS] = 12'($urandom_range(thr_set[i], 0));
        end
        return f;
    endfunction

    // contiguous strip of one to three sensors, as a real line looks
    function automatic logic [7:0] line_pattern();
        int w;
        w = $urandom_range(3, 1);
        return 8'(((1 << w) - 1) << $urandom_range(8 - w, 0));
    endfunction

    // a pattern that brings the robot out of a spin turn
    function automatic logic [7:0] center_pattern();
        return line_pattern() | ($urandom_range(1) ? 8'h08 : 8'h10);
    endfunction

    // Offer one frame; tvalid stays high after the transaction so that
    // back-to-back frames need no second assignment in the same step.
    task automatic send_frame(input logic [IN_W-1:0] f);
        if ($urandom_range(99) < sender_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    task automatic send_pattern(input logic [7:0] pat);
        send_frame(frame_for(pat));
    endtask

    // Drop tvalid and wait for every outstanding result, then let the
    // pipeline run empty before anything else touches the block.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_steer != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write every register from thr_set and the given gains; only called idle.
    task automatic apply_setup(input logic [7:0] kp, input logic [7:0] kd,
                               input logic [7:0] limit, input logic [7:0] base_l,
                               input logic [7:0] base_r, input logic [7:0] spin);
        write_reg(REG_THR_LO, {thr_set[3], thr_set[2], thr_set[1], thr_set[0]});
        write_reg(REG_THR_HI, {thr_set[7], thr_set[6], thr_set[5], thr_set[4]});
        write_reg(REG_PROP_GAIN, {40'd0, kp});
        write_reg(REG_DERIV_GAIN, {40'd0, kd});
        write_reg(REG_SPEED_LIMIT, {40'd0, limit});
        write_reg(REG_LEFT_BASE, {40'd0, base_l});
        write_reg(REG_RIGHT_BASE, {40'd0, base_r});
        write_reg(REG_SPIN_SPEED, {40'd0, spin});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_thresholds();
        foreach (thr_set[i])
            thr_set[i] = 12'($urandom_range(3900, 100));
    endtask

    task automatic random_setup();
        random_thresholds();
        apply_setup(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
    endtask

    // Mostly well-formed track sequences: straight line, lost line with an
    // optional edge hint, all-black crossings and stops; the rest is noise.
    task automatic run_track(input int unsigned count);
        int unsigned goal;
        int unsigned pick;
        goal = sent_items + count;
        while (sent_items < goal) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                repeat ($urandom_range(4, 1)) send_pattern(line_pattern());
            end else if (pick < 60) begin
                case ($urandom_range(2))
                    0:       send_pattern(8'($urandom_range(3, 1)));
                    1:       send_pattern({2'($urandom_range(3, 1)), 6'd0});
                    default: ;
                endcase
                send_pattern(8'h00);
                repeat ($urandom_range(3)) send_pattern(8'($urandom_range(255)) & 8'hE7);
                send_pattern(center_pattern());
            end else if (pick < 75) begin
                send_pattern(8'hFF);
                case ($urandom_range(2))
                    0: begin
                        send_pattern(8'hFF);
                        repeat ($urandom_range(3)) send_pattern(8'hFF);
                    end
                    1:       send_pattern(8'h00);
                    default: ;
                endcase
                send_pattern(line_pattern());
            end else if (pick < 90) begin
                send_pattern(8'($urandom_range(255)));
            end else begin
                send_frame({$urandom, $urandom, $urandom});
            end
        end
    endtask

    initial begin
        foreach (thr_set[i])
            thr_set[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk under the reset configuration, thresholds all zero:
        // position before any sighting, lost line with left, right and no
        // remembered turn, stop confirmation, T-section, stop and restart,
        // and the outermost positions.
        send_pattern(8'h00);
        send_pattern(8'h18);
        send_pattern(8'h01);
        send_pattern(8'h00);
        send_pattern(8'h00);
        send_pattern(8'h80);
        send_pattern(8'h08);
        send_pattern(8'hC0);
        send_pattern(8'h00);
        send_pattern(8'h10);
        send_pattern(8'h00);
        send_pattern(8'h18);
        send_pattern(8'hFF);
        send_pattern(8'h3C);
        send_pattern(8'hFF);
        send_pattern(8'h00);
        send_pattern(8'h08);
        send_frame('1);
        send_pattern(8'hFF);
        send_pattern(8'hFF);
        send_pattern(8'h7E);
        send_pattern(8'h01);
        send_pattern(8'h80);
        send_pattern(8'hAA);
        drain();

        // random settings, with the long result hold-off
        random_setup();
        hold_armed <= 1'b1;
        run_track(85);
        drain();

        // high extremes: full gains, spin faster than the limit, zero thresholds and
        // sensors that never see the line
        thr_set = '{12'h000, 12'hFFF, 12'h001, 12'h7FF, 12'hFFE, 12'h000, 12'h800, 12'hFFF};
        apply_setup(8'd255, 8'd255, 8'd100, 8'd255, 8'd0, 8'd255);
        run_track(85);
        drain();

        // low extremes, with the idle shares swapped
        sender_pct = 55;
        recv_pct   = 20;
        random_thresholds();
        apply_setup(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0);
        run_track(85);
        drain();

        random_thresholds();
        apply_setup(8'($urandom), 8'($urandom), 8'd255, 8'($urandom), 8'($urandom),
                    8'($urandom));
        run_track(85);
        drain();

        // no idling on either side
        sender_pct = 0;
        recv_pct   = 0;
        random_setup();
        run_track(85);
        drain();

        if (fault_total == 0)
            $display("[line_follower_pd_controller] OK");
        else
            $display("[line_follower_pd_controller] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("[line_follower_pd_controller] ERROR");
        $finish;
    end

endmodule

FILE: line_follower_pd_controller.f
design/lfpd_pkg.sv
design/lfpd_lane.sv
design/lfpd_merge.sv
design/lfpd_div.sv
design/lfpd_ctrl.sv
design/line_follower_pd_controller.sv
verif/lfpd_steer_checker.sv
verif/tb_line_follower_pd_controller.sv
